### rtl/assert_macros.svh
// assertion macros used by the rtl file lfu_cache_table.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

### rtl/lfu_pkg.sv
// types and constants of the lfu cache table
`timescale 1ns / 1ps

package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int COUNT_W = 16;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic signed [KEY_W-1:0] lookup_key;
		logic signed [KEY_W-1:0] store_value;
	} lfu_req_t;

	typedef struct packed {
		logic                    found;
		logic signed [KEY_W-1:0] read_value;
	} lfu_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SETTLE,
		ST_CHOOSE,
		ST_UPDATE,
		ST_RESULT
	} lfu_state_t;

	typedef struct packed {
		logic load_req;
		logic rd_en;
		logic upd_pass;
		logic load_out;
	} lfu_cmd_t;

	typedef struct packed {
		logic need_update;
		logic out_free;
	} lfu_sts_t;

endpackage

### rtl/lfu_ctrl.sv
// sequencer for the search and rewrite sweeps of the lfu cache table
`timescale 1ns / 1ps

module lfu_ctrl #(
	parameter int ENTRIES = 16,
	localparam int IW = $clog2(ENTRIES > 1 ? ENTRIES : 2)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lfu_pkg::lfu_sts_t sts,
	output lfu_pkg::lfu_cmd_t cmd,
	output logic [IW-1:0]     addr
);
	import lfu_pkg::*;

	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	lfu_state_t    state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic          last;

	assign last = (idx_q == LAST_IDX);
	assign addr = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					idx_d        = '0;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (last) begin
					idx_d   = '0;
					state_d = ST_SETTLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_SETTLE: begin
				state_d = ST_CHOOSE;
			end
			ST_CHOOSE: begin
				state_d = sts.need_update ? ST_UPDATE : ST_RESULT;
			end
			ST_UPDATE: begin
				cmd.rd_en    = 1'b1;
				cmd.upd_pass = 1'b1;
				if (last) begin
					idx_d   = '0;
					state_d = ST_RESULT;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/lfu_dpath.sv
// entry memory, search accumulators, rank rewrite and result register
`timescale 1ns / 1ps

module lfu_dpath #(
	parameter int ENTRIES = 16,
	localparam int IW = $clog2(ENTRIES > 1 ? ENTRIES : 2)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lfu_pkg::lfu_cmd_t         cmd,
	input  logic [IW-1:0]             addr,
	input  logic                      cfg_wr_en,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_wr_data,
	input  lfu_pkg::lfu_req_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output lfu_pkg::lfu_rsp_t         out_data,
	output lfu_pkg::lfu_sts_t         sts
);
	import lfu_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int OW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [OW-1:0] ENT_EXT = OW'(ENTRIES);

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [KEY_W-1:0]   value;
		logic [COUNT_W-1:0] count;
		logic [IW-1:0]      rank;
	} ent_t;

	ent_t ent_q [ENTRIES];

	logic [CAP_W-1:0]   cap_q;
	logic [OW-1:0]      req_cap_q;
	lfu_req_t           req_q;
	logic [CW-1:0]      occ_q;
	logic [ENTRIES-1:0] valid_q;

	ent_t          rd_data_s1;
	logic          rd_vld_s1;
	logic          rd_pass_s1;
	logic [IW-1:0] rd_idx_s1;

	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic [KEY_W-1:0]   hit_val_q;
	logic [IW-1:0]      hit_rank_q;
	logic               vic_found_q;
	logic [IW-1:0]      vic_idx_q;
	logic [COUNT_W-1:0] vic_cnt_q;
	logic [IW-1:0]      vic_rank_q;
	logic               ff_found_q;
	logic [IW-1:0]      ff_idx_q;

	logic          out_valid_q;
	lfu_rsp_t      out_q;

	logic          cap_eff_zero;
	logic          is_set;
	logic          do_touch;
	logic          do_evict;
	logic          do_insert;
	logic          slot_ok;
	logic [IW-1:0] slot_idx;
	logic [OW-1:0] cap_in_ext;
	logic [OW-1:0] cap_in_eff;

	logic          cur_valid;
	logic          scan_step;
	logic          upd_step;
	logic          key_eq;
	logic          better_vic;
	logic          rank_gt;
	logic          wr_en;
	ent_t          wr_data;
	logic          set_valid;
	logic          clr_valid;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	assign cap_in_ext = OW'(cap_q);
	assign cap_in_eff = (cap_in_ext > ENT_EXT) ? ENT_EXT : cap_in_ext;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q     <= in_data;
			req_cap_q <= cap_in_eff;
		end
	end

	// entry memory, one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= ent_q[addr];
		end
		if (wr_en) begin
			ent_q[rd_idx_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			rd_pass_s1 <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			rd_vld_s1  <= cmd.rd_en;
			rd_pass_s1 <= cmd.upd_pass;
			rd_idx_s1  <= addr;
		end
	end

	assign cur_valid = valid_q[rd_idx_s1];
	assign scan_step = rd_vld_s1 && !rd_pass_s1;
	assign upd_step  = rd_vld_s1 && rd_pass_s1;
	assign key_eq    = (rd_data_s1.key == $unsigned(req_q.lookup_key));
	assign better_vic = !vic_found_q || (rd_data_s1.count < vic_cnt_q) ||
		((rd_data_s1.count == vic_cnt_q) && (rd_data_s1.rank > vic_rank_q));

	// search sweep: key match, victim and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			vic_found_q <= 1'b0;
			ff_found_q  <= 1'b0;
		end else if (cmd.load_req) begin
			hit_q       <= 1'b0;
			vic_found_q <= 1'b0;
			ff_found_q  <= 1'b0;
		end else if (scan_step) begin
			if (cur_valid && key_eq && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (cur_valid && better_vic) begin
				vic_found_q <= 1'b1;
			end
			if (!cur_valid && !ff_found_q) begin
				ff_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_step) begin
			if (cur_valid && key_eq && !hit_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_val_q  <= rd_data_s1.value;
				hit_rank_q <= rd_data_s1.rank;
			end
			if (cur_valid && better_vic) begin
				vic_idx_q  <= rd_idx_s1;
				vic_cnt_q  <= rd_data_s1.count;
				vic_rank_q <= rd_data_s1.rank;
			end
			if (!cur_valid && !ff_found_q) begin
				ff_idx_q <= rd_idx_s1;
			end
		end
	end

	// decision from the finished search
	assign is_set       = (req_q.opcode == OP_SET);
	assign cap_eff_zero = (req_cap_q == '0);
	assign do_touch     = hit_q && (!is_set || !cap_eff_zero);
	assign do_evict     = is_set && !hit_q && !cap_eff_zero && vic_found_q &&
		(OW'(occ_q) >= req_cap_q);
	assign slot_ok      = do_evict || ff_found_q;
	assign slot_idx     = (do_evict && !(ff_found_q && (ff_idx_q < vic_idx_q))) ?
		vic_idx_q : ff_idx_q;
	assign do_insert    = is_set && !hit_q && !cap_eff_zero && slot_ok;
	assign rank_gt      = do_evict && (rd_data_s1.rank > vic_rank_q);

	// rewrite sweep
	always_comb begin
		wr_en     = 1'b0;
		wr_data   = rd_data_s1;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		if (upd_step) begin
			if (do_touch) begin
				if (cur_valid) begin
					wr_en = 1'b1;
					if (rd_idx_s1 == hit_idx_q) begin
						wr_data.rank  = '0;
						wr_data.count = (rd_data_s1.count == COUNT_MAX) ?
							COUNT_MAX : rd_data_s1.count + 1'b1;
						if (is_set) begin
							wr_data.value = $unsigned(req_q.store_value);
						end
					end else if (rd_data_s1.rank < hit_rank_q) begin
						wr_data.rank = rd_data_s1.rank + 1'b1;
					end
				end
			end else if (do_insert) begin
				if (rd_idx_s1 == slot_idx) begin
					wr_en         = 1'b1;
					set_valid     = 1'b1;
					wr_data.key   = $unsigned(req_q.lookup_key);
					wr_data.value = $unsigned(req_q.store_value);
					wr_data.count = COUNT_W'(1);
					wr_data.rank  = '0;
				end else if (cur_valid && do_evict && (rd_idx_s1 == vic_idx_q)) begin
					clr_valid = 1'b1;
				end else if (cur_valid) begin
					wr_en        = 1'b1;
					wr_data.rank = rd_data_s1.rank - IW'(rank_gt) + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (set_valid) begin
			valid_q[rd_idx_s1] <= 1'b1;
		end else if (clr_valid) begin
			valid_q[rd_idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.load_out) begin
			occ_q <= occ_q + CW'(do_insert) - CW'(do_evict);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.found      <= hit_q;
			out_q.read_value <= (!is_set && hit_q) ? $signed(hit_val_q) : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign sts.need_update = do_touch || do_insert;
	assign sts.out_free    = !out_valid_q || !out_stall;

endmodule

### rtl/lfu_cache_table.sv
// Key/value cache with least-frequently-used replacement and least-recent
// tie break, ENTRIES entries held in one entry memory with one read and one
// write port. Each request is swept over the memory once to find the key,
// the victim and the first free entry; a get hit, a set hit (capacity not
// zero) and an insert then sweep it a second time to rewrite values, use
// counts and recency ranks. One request is in flight at a time: a request
// that changes the table is swept twice, one that does not once, with one
// memory read per cycle. The result sits in an output register and is held
// while out_stall is high. The user must write capacity through cfg_wr_en /
// cfg_wr_data only while no request is in flight; the block itself does not
// enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfu_cache_table #(
	parameter int ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  lfu_pkg::lfu_req_t         in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output lfu_pkg::lfu_rsp_t         out_data,
	input  logic                      cfg_wr_en,
	input  logic [lfu_pkg::CAP_W-1:0] cfg_wr_data
);
	import lfu_pkg::*;

	localparam int IW = $clog2(ENTRIES > 1 ? ENTRIES : 2);

	lfu_cmd_t      cmd;
	lfu_sts_t      sts;
	logic [IW-1:0] addr;

	lfu_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd),
		.addr    (addr)
	);

	lfu_dpath #(
		.ENTRIES(ENTRIES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.addr       (addr),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.sts        (sts)
	);

	`ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && !in_stall, in_stall)
	`ASSERT_IMPL(a_load_only_when_free, clk, arst_n, cmd.load_out, sts.out_free)
	`ASSERT_IMPL(a_rewrite_needed, clk, arst_n, cmd.rd_en && cmd.upd_pass, sts.need_update)
	`ASSERT_NEXT(a_result_shown, clk, arst_n, cmd.load_out, out_valid)

endmodule
